// ===== design/pbpa_pkg.sv =====
// ----------------------------------------------------------------------------
// pbpa_pkg: shared types and constants of the paged block pool allocator
// Payload structs, register indexes, sizes and the controller state type.
// ----------------------------------------------------------------------------
package pbpa_pkg;

   localparam int PAGE_CAP   = 16;
   localparam int SLOTS_CAP  = 64;
   localparam int LINK_BYTES = 8;
   localparam int BLOCK_IDS  = PAGE_CAP * SLOTS_CAP;

   localparam int PAGE_W  = $clog2(PAGE_CAP);
   localparam int SLOT_W  = $clog2(SLOTS_CAP);
   localparam int ID_W    = PAGE_W + SLOT_W;
   localparam int CNT_W   = ID_W + 1;
   localparam int OFF_W   = 19;
   localparam int BS_W    = 13;
   localparam int CSR_W   = 13;
   localparam int CSRI_W  = 3;

   localparam logic [CSRI_W-1:0] REG_OBJECT_BYTES = 3'd0;
   localparam logic [CSRI_W-1:0] REG_OBJS_PER_PG  = 3'd1;
   localparam logic [CSRI_W-1:0] REG_HEADER_BYTES = 3'd2;
   localparam logic [CSRI_W-1:0] REG_PAD_BYTES    = 3'd3;
   localparam logic [CSRI_W-1:0] REG_MAX_PAGES    = 3'd4;
   localparam logic [CSRI_W-1:0] REG_DEBUG_ON     = 3'd5;

   localparam logic       KIND_ALLOC = 1'b0;
   localparam logic       KIND_FREE  = 1'b1;
   localparam logic [1:0] ST_OK           = 2'd0;
   localparam logic [1:0] ST_OUT_OF_PAGES = 2'd1;
   localparam logic [1:0] ST_MULTI_FREE   = 2'd2;
   localparam logic [1:0] ST_BAD_BOUNDARY = 2'd3;

   typedef struct packed {
      logic              kind;
      logic [3:0]        free_page;
      logic [OFF_W-1:0]  free_offset;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [3:0]        block_page;
      logic [OFF_W-1:0]  block_offset;
      logic [31:0]       alloc_number;
      logic [10:0]       free_count;
      logic [10:0]       in_use_count;
   } rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ADD,
      S_POP,
      S_POP_WAIT,
      S_DIV,
      S_CHECK,
      S_DONE
   } state_type;

endpackage

// ===== design/pbpa_divider.sv =====
// ----------------------------------------------------------------------------
// pbpa_divider: iterative restoring divider
// Divides a byte offset by the block size, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pbpa_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [pbpa_pkg::OFF_W-1:0]    dividend,
   input  logic [pbpa_pkg::BS_W-1:0]     divisor,
   output logic [pbpa_pkg::OFF_W-1:0]    quotient,
   output logic [pbpa_pkg::BS_W-1:0]     remainder,
   output pbpa_pkg::div_status_type      status
);

   logic [pbpa_pkg::BS_W-1:0]  rem_ff, rem_in;
   logic [pbpa_pkg::OFF_W-1:0] quo_ff, quo_in;
   logic [pbpa_pkg::BS_W-1:0]  dvs_ff, dvs_in;
   logic [4:0]                 cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [pbpa_pkg::BS_W:0]    trial;
   logic                       ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[pbpa_pkg::OFF_W-1]};
      ge      = trial >= {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = 5'(pbpa_pkg::OFF_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? pbpa_pkg::BS_W'(trial - {1'b0, dvs_ff})
                     : trial[pbpa_pkg::BS_W-1:0];
         quo_in = {quo_ff[pbpa_pkg::OFF_W-2:0], ge};
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient    = quo_ff;
   assign remainder   = rem_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// ===== design/paged_block_pool_allocator.sv =====
// ----------------------------------------------------------------------------
// paged_block_pool_allocator: fixed-size block pool with a LIFO free stack
// An allocate goes S_POP, S_POP_WAIT, S_DONE, after an S_ADD page sweep if the stack is
// empty; an out-of-pages allocate or early-rejected free goes straight to S_DONE; a free
// runs the 19-step divider in S_DIV, then S_CHECK and S_DONE (S_DONE directly if the slot
// is out of range). The result waits in S_DONE while the output register is stalled. One
// transaction at a time; the next is accepted once the controller is back in S_IDLE.
// Reset is synchronous and empties the pool; each page sweep clears its in-use bits.
// ----------------------------------------------------------------------------
module paged_block_pool_allocator (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  pbpa_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output pbpa_pkg::rsp_type                rsp_data,
   input  logic                             csr_we,
   input  logic [pbpa_pkg::CSRI_W-1:0]      csr_index,
   input  logic [pbpa_pkg::CSR_W-1:0]       csr_wdata
);

   // Configuration registers, kept raw and saturated where they are used.
   logic [12:0] obj_ff;
   logic [6:0]  opp_ff;
   logic [5:0]  hdr_ff;
   logic [6:0]  pad_ff;
   logic [4:0]  maxp_ff;
   logic        dbg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         obj_ff  <= 13'd8;
         opp_ff  <= 7'd4;
         hdr_ff  <= 6'd0;
         pad_ff  <= 7'd0;
         maxp_ff <= 5'd16;
         dbg_ff  <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            pbpa_pkg::REG_OBJECT_BYTES: obj_ff  <= csr_wdata[12:0];
            pbpa_pkg::REG_OBJS_PER_PG:  opp_ff  <= csr_wdata[6:0];
            pbpa_pkg::REG_HEADER_BYTES: hdr_ff  <= csr_wdata[5:0];
            pbpa_pkg::REG_PAD_BYTES:    pad_ff  <= csr_wdata[6:0];
            pbpa_pkg::REG_MAX_PAGES:    maxp_ff <= csr_wdata[4:0];
            pbpa_pkg::REG_DEBUG_ON:     dbg_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Effective (saturated) configuration values and derived geometry.
   logic [12:0]                   eff_obj;
   logic [6:0]                    eff_slots;
   logic [5:0]                    eff_hdr;
   logic [6:0]                    eff_pad;
   logic [4:0]                    eff_max;
   logic [pbpa_pkg::BS_W-1:0]     blk_size;
   logic [pbpa_pkg::OFF_W-1:0]    first_off;

   always_comb begin
      eff_obj   = (obj_ff == 13'd0) ? 13'd1 : ((obj_ff > 13'd4096) ? 13'd4096 : obj_ff);
      eff_slots = (opp_ff == 7'd0) ? 7'd1
                : ((opp_ff > 7'(pbpa_pkg::SLOTS_CAP)) ? 7'(pbpa_pkg::SLOTS_CAP) : opp_ff);
      eff_hdr   = (hdr_ff > 6'd32) ? 6'd32 : hdr_ff;
      eff_pad   = (pad_ff > 7'd64) ? 7'd64 : pad_ff;
      eff_max   = (maxp_ff > 5'(pbpa_pkg::PAGE_CAP)) ? 5'(pbpa_pkg::PAGE_CAP) : maxp_ff;
      blk_size  = eff_obj + {5'd0, eff_pad, 1'b0} + {7'd0, eff_hdr};
      first_off = pbpa_pkg::OFF_W'(pbpa_pkg::LINK_BYTES) + {13'd0, eff_hdr}
                + {12'd0, eff_pad};
   end

   // Pool state.
   pbpa_pkg::state_type            state_ff, state_in;
   logic                           kind_ff, kind_in;
   logic [3:0]                     fpage_ff, fpage_in;
   logic [pbpa_pkg::OFF_W-1:0]     foff_ff, foff_in;
   logic [pbpa_pkg::SLOT_W:0]      sweep_ff, sweep_in;
   logic [pbpa_pkg::CNT_W-1:0]     depth_ff, depth_in;
   logic [4:0]                     pages_ff, pages_in;
   logic [31:0]                    alloc_ff, alloc_in;
   logic [pbpa_pkg::CNT_W-1:0]     live_ff, live_in;
   logic [1:0]                     res_status_ff, res_status_in;
   logic [3:0]                     res_page_ff, res_page_in;
   logic [pbpa_pkg::OFF_W-1:0]     res_off_ff, res_off_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   pbpa_pkg::rsp_type              rsp_data_ff, rsp_data_in;

   // Free stack and in-use bit memories, one write and one registered read each.
   logic [pbpa_pkg::ID_W-1:0]      stack_mem [pbpa_pkg::BLOCK_IDS];
   logic                           inuse_mem [pbpa_pkg::BLOCK_IDS];
   logic                           stk_we, use_we, use_wdata;
   logic [pbpa_pkg::ID_W-1:0]      stk_waddr, stk_wdata, stk_raddr, stk_rdata_ff;
   logic [pbpa_pkg::ID_W-1:0]      use_waddr, use_raddr;
   logic                           use_rdata_ff;

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stack_mem[stk_waddr] <= stk_wdata;
      end
      if (use_we) begin
         inuse_mem[use_waddr] <= use_wdata;
      end
      stk_rdata_ff <= stack_mem[stk_raddr];
      use_rdata_ff <= inuse_mem[use_raddr];
   end

   // Divider: splits the offset from slot 0 into slot and remainder.
   logic                           div_start;
   logic [pbpa_pkg::OFF_W-1:0]     div_quo;
   logic [pbpa_pkg::BS_W-1:0]      div_rem;
   pbpa_pkg::div_status_type       div_status;

   pbpa_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (foff_in - first_off),
      .divisor   (blk_size),
      .quotient  (div_quo),
      .remainder (div_rem),
      .status    (div_status)
   );

   logic                           req_take;
   logic [pbpa_pkg::ID_W-1:0]      pop_id, free_id;
   logic [pbpa_pkg::OFF_W-1:0]     pop_off;
   logic                           free_ok;

   assign req_take = req_valid && !req_stall;
   assign pop_id   = stk_rdata_ff;
   assign pop_off  = first_off
                   + pbpa_pkg::OFF_W'(pop_id[pbpa_pkg::SLOT_W-1:0])
                     * pbpa_pkg::OFF_W'(blk_size);
   assign free_id  = {fpage_ff, div_quo[pbpa_pkg::SLOT_W-1:0]};

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      fpage_in      = fpage_ff;
      foff_in       = foff_ff;
      sweep_in      = sweep_ff;
      depth_in      = depth_ff;
      pages_in      = pages_ff;
      alloc_in      = alloc_ff;
      live_in       = live_ff;
      res_status_in = res_status_ff;
      res_page_in   = res_page_ff;
      res_off_in    = res_off_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      req_stall     = (state_ff != pbpa_pkg::S_IDLE);
      stk_we        = 1'b0;
      stk_waddr     = depth_ff[pbpa_pkg::ID_W-1:0];
      stk_wdata     = '0;
      stk_raddr     = pbpa_pkg::ID_W'(depth_ff - 1'b1);
      use_we        = 1'b0;
      use_waddr     = '0;
      use_wdata     = 1'b0;
      use_raddr     = free_id;
      div_start     = 1'b0;
      free_ok       = 1'b0;

      case (state_ff)
         pbpa_pkg::S_IDLE: begin
            if (req_take) begin
               kind_in       = req_data.kind;
               fpage_in      = req_data.free_page;
               foff_in       = req_data.free_offset;
               res_status_in = pbpa_pkg::ST_OK;
               res_page_in   = '0;
               res_off_in    = '0;
               if (req_data.kind == pbpa_pkg::KIND_ALLOC) begin
                  if (depth_ff != '0) begin
                     state_in = pbpa_pkg::S_POP;
                  end else if (pages_ff < eff_max) begin
                     sweep_in = '0;
                     state_in = pbpa_pkg::S_ADD;
                  end else begin
                     res_status_in = pbpa_pkg::ST_OUT_OF_PAGES;
                     state_in      = pbpa_pkg::S_DONE;
                  end
               end else if ({1'b0, req_data.free_page} >= pages_ff ||
                            req_data.free_offset < first_off) begin
                  res_status_in = pbpa_pkg::ST_BAD_BOUNDARY;
                  state_in      = pbpa_pkg::S_DONE;
               end else begin
                  div_start = 1'b1;
                  state_in  = pbpa_pkg::S_DIV;
               end
            end
         end

         // Page sweep: clear every in-use bit of the new page and push the
         // configured slots in ascending order, so the last slot ends on top.
         pbpa_pkg::S_ADD: begin
            use_we    = 1'b1;
            use_waddr = {pages_ff[pbpa_pkg::PAGE_W-1:0], sweep_ff[pbpa_pkg::SLOT_W-1:0]};
            use_wdata = 1'b0;
            if (sweep_ff < eff_slots && depth_ff < pbpa_pkg::CNT_W'(pbpa_pkg::BLOCK_IDS)) begin
               stk_we    = 1'b1;
               stk_wdata = use_waddr;
               depth_in  = depth_ff + 1'b1;
            end
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == (pbpa_pkg::SLOT_W+1)'(pbpa_pkg::SLOTS_CAP - 1)) begin
               pages_in = pages_ff + 5'd1;
               state_in = pbpa_pkg::S_POP;
            end
         end

         pbpa_pkg::S_POP: begin
            depth_in = depth_ff - 1'b1;
            state_in = pbpa_pkg::S_POP_WAIT;
         end

         pbpa_pkg::S_POP_WAIT: begin
            use_we      = 1'b1;
            use_waddr   = pop_id;
            use_wdata   = 1'b1;
            alloc_in    = alloc_ff + 32'd1;
            live_in     = live_ff + 1'b1;
            res_page_in = pop_id[pbpa_pkg::ID_W-1:pbpa_pkg::SLOT_W];
            res_off_in  = pop_off;
            state_in    = pbpa_pkg::S_DONE;
         end

         // The in-use read is issued from the quotient as the divider ends.
         pbpa_pkg::S_DIV: begin
            if (div_status.done) begin
               if (div_quo >= pbpa_pkg::OFF_W'(eff_slots)) begin
                  res_status_in = pbpa_pkg::ST_BAD_BOUNDARY;
                  state_in      = pbpa_pkg::S_DONE;
               end else begin
                  state_in = pbpa_pkg::S_CHECK;
               end
            end
         end

         pbpa_pkg::S_CHECK: begin
            free_ok = 1'b1;
            if (dbg_ff) begin
               if (div_rem == '0 && !use_rdata_ff) begin
                  res_status_in = pbpa_pkg::ST_MULTI_FREE;
                  free_ok       = 1'b0;
               end else if (div_rem != '0) begin
                  res_status_in = pbpa_pkg::ST_BAD_BOUNDARY;
                  free_ok       = 1'b0;
               end
            end
            if (free_ok && use_rdata_ff) begin
               use_we    = 1'b1;
               use_waddr = free_id;
               use_wdata = 1'b0;
               if (depth_ff < pbpa_pkg::CNT_W'(pbpa_pkg::BLOCK_IDS)) begin
                  stk_we    = 1'b1;
                  stk_wdata = free_id;
                  depth_in  = depth_ff + 1'b1;
               end
               if (live_ff != '0) begin
                  live_in = live_ff - 1'b1;
               end
            end
            state_in = pbpa_pkg::S_DONE;
         end

         // Hand the result to the output register once it is free.
         pbpa_pkg::S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.status        = res_status_ff;
               rsp_data_in.block_page    = res_page_ff;
               rsp_data_in.block_offset  = res_off_ff;
               rsp_data_in.alloc_number  = alloc_ff;
               rsp_data_in.free_count    = depth_ff;
               rsp_data_in.in_use_count  = live_ff;
               state_in                  = pbpa_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = pbpa_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      fpage_ff      <= fpage_in;
      foff_ff       <= foff_in;
      sweep_ff      <= sweep_in;
      res_status_ff <= res_status_in;
      res_page_ff   <= res_page_in;
      res_off_ff    <= res_off_in;
      rsp_data_ff   <= rsp_data_in;
      if (reset) begin
         state_ff     <= pbpa_pkg::S_IDLE;
         depth_ff     <= '0;
         pages_ff     <= '0;
         alloc_ff     <= '0;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         pages_ff     <= pages_in;
         alloc_ff     <= alloc_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the paged block pool allocator
// A directed table, then phases of random allocate and free traffic under
// several register settings and idle patterns, checked against a behavioral
// pool model kept inside the testbench or against results given in the table.
// ----------------------------------------------------------------------------
module tb_top;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   pbpa_pkg::req_type               req_data;
   logic                            rsp_valid;
   logic                            rsp_stall;
   pbpa_pkg::rsp_type               rsp_data;
   logic                            csr_we;
   logic [pbpa_pkg::CSRI_W-1:0]     csr_index;
   logic [pbpa_pkg::CSR_W-1:0]      csr_wdata;

   paged_block_pool_allocator i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Pool model: a copy of the registers and of the allocator state.
   int unsigned pool_cfg [6];
   int unsigned free_ids [pbpa_pkg::BLOCK_IDS];
   bit          id_live  [pbpa_pkg::BLOCK_IDS];
   int unsigned free_depth;
   int unsigned page_count;
   int unsigned alloc_total;
   int unsigned live_total;

   // Expected results, oldest first.
   pbpa_pkg::rsp_type pending_rsp [$];
   int unsigned error_count;
   int unsigned accepted_count;
   int unsigned checked_count;
   int unsigned status_seen [4];

   // Handed from the sender to the acceptance monitor with each transaction.
   bit                cur_typed;
   pbpa_pkg::rsp_type cur_typed_rsp;

   // Idle pattern of the current phase and the long receiver hold-off.
   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;
   int unsigned hold_left;

   typedef struct {
      bit                          is_csr;
      logic [pbpa_pkg::CSRI_W-1:0] reg_index;
      int unsigned                 reg_value;
      pbpa_pkg::req_type           item;
      bit                          typed;
      pbpa_pkg::rsp_type           typed_rsp;
   } row_type;

   row_type directed_rows [$];

   // -------------------------------------------------------------------------
   // Clock and timeout
   // -------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The slowest correct run is far below this: every transaction waits at
   // most a page sweep plus the stall and idle stretches of its phase.
   initial begin
      #20ms;
      $display("DONE: errors detected");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Model helpers
   // -------------------------------------------------------------------------
   function automatic int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic int unsigned slots_now();
      return clip(pool_cfg[pbpa_pkg::REG_OBJS_PER_PG], 1, pbpa_pkg::SLOTS_CAP);
   endfunction

   function automatic int unsigned first_now();
      return pbpa_pkg::LINK_BYTES + clip(pool_cfg[pbpa_pkg::REG_HEADER_BYTES], 0, 32)
             + clip(pool_cfg[pbpa_pkg::REG_PAD_BYTES], 0, 64);
   endfunction

   function automatic int unsigned stride_now();
      return clip(pool_cfg[pbpa_pkg::REG_OBJECT_BYTES], 1, 4096)
             + 2 * clip(pool_cfg[pbpa_pkg::REG_PAD_BYTES], 0, 64)
             + clip(pool_cfg[pbpa_pkg::REG_HEADER_BYTES], 0, 32);
   endfunction

   function automatic int unsigned max_now();
      return clip(pool_cfg[pbpa_pkg::REG_MAX_PAGES], 0, pbpa_pkg::PAGE_CAP);
   endfunction

   // Applies one request to the model and returns the result it must give.
   function automatic pbpa_pkg::rsp_type pool_apply(pbpa_pkg::req_type r);
      pbpa_pkg::rsp_type res;
      int unsigned       first;
      int unsigned       stride;
      int unsigned       rel;
      int unsigned       id;
      bit                aligned;
      first  = first_now();
      stride = stride_now();
      res    = '0;
      res.status = pbpa_pkg::ST_OK;
      if (r.kind == pbpa_pkg::KIND_ALLOC) begin
         // An empty stack grows the pool by one page, slot N-1 ending on top.
         if (free_depth == 0 && page_count < max_now()) begin
            for (int unsigned s = 0; s < slots_now(); s++) begin
               free_ids[free_depth] = page_count * pbpa_pkg::SLOTS_CAP + s;
               free_depth++;
            end
            page_count++;
         end
         if (free_depth == 0) begin
            res.status = pbpa_pkg::ST_OUT_OF_PAGES;
         end else begin
            free_depth--;
            id = free_ids[free_depth];
            id_live[id] = 1'b1;
            alloc_total++;
            live_total++;
            res.block_page   = pbpa_pkg::PAGE_W'(id / pbpa_pkg::SLOTS_CAP);
            res.block_offset = pbpa_pkg::OFF_W'(first + (id % pbpa_pkg::SLOTS_CAP) * stride);
         end
      end else begin
         if (r.free_page >= page_count || r.free_offset < first
             || (r.free_offset - first) / stride >= slots_now()) begin
            res.status = pbpa_pkg::ST_BAD_BOUNDARY;
         end else begin
            rel     = r.free_offset - first;
            id      = r.free_page * pbpa_pkg::SLOTS_CAP + rel / stride;
            aligned = (rel % stride) == 0;
            if (pool_cfg[pbpa_pkg::REG_DEBUG_ON] != 0) begin
               if (aligned && !id_live[id])
                  res.status = pbpa_pkg::ST_MULTI_FREE;
               else if (!aligned)
                  res.status = pbpa_pkg::ST_BAD_BOUNDARY;
            end
            // Outside debug mode a free of an idle block changes nothing.
            if (res.status == pbpa_pkg::ST_OK && id_live[id]) begin
               id_live[id] = 1'b0;
               free_ids[free_depth] = id;
               free_depth++;
               if (live_total > 0)
                  live_total--;
            end
         end
      end
      res.alloc_number = alloc_total;
      res.free_count   = pbpa_pkg::CNT_W'(free_depth);
      res.in_use_count = pbpa_pkg::CNT_W'(live_total);
      return res;
   endfunction

   // -------------------------------------------------------------------------
   // Monitors: both sample at the rising edge, before the block updates.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      pbpa_pkg::rsp_type predicted;
      if (!reset && req_valid && !req_stall) begin
         predicted = pool_apply(req_data);
         pending_rsp.push_back(cur_typed ? cur_typed_rsp : predicted);
         accepted_count++;
      end
   end

   task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      pbpa_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("result transaction with nothing expected", 1, 0);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.status != want.status)
               report_mismatch("status", rsp_data.status, want.status);
            if (rsp_data.block_page != want.block_page)
               report_mismatch("block_page", rsp_data.block_page, want.block_page);
            if (rsp_data.block_offset != want.block_offset)
               report_mismatch("block_offset", rsp_data.block_offset, want.block_offset);
            if (rsp_data.alloc_number != want.alloc_number)
               report_mismatch("alloc_number", rsp_data.alloc_number, want.alloc_number);
            if (rsp_data.free_count != want.free_count)
               report_mismatch("free_count", rsp_data.free_count, want.free_count);
            if (rsp_data.in_use_count != want.in_use_count)
               report_mismatch("in_use_count", rsp_data.in_use_count, want.in_use_count);
            status_seen[want.status]++;
            checked_count++;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Receiver: random stalls per phase, or a long hold-off when requested.
   // -------------------------------------------------------------------------
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else begin
            rsp_stall = ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Sender side
   // -------------------------------------------------------------------------
   // Offers one transaction and returns at the falling edge after it was taken.
   // Valid stays high so that the next transaction can follow without a gap.
   task automatic send_req(pbpa_pkg::req_type r, bit typed, pbpa_pkg::rsp_type typed_rsp);
      int unsigned taken_before;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_data      = r;
      cur_typed     = typed;
      cur_typed_rsp = typed_rsp;
      req_valid     = 1'b1;
      taken_before  = accepted_count;
      do @(negedge clock); while (accepted_count == taken_before);
   endtask

   // Waits until every expected result is in, then lets a page sweep pass.
   task automatic drain();
      req_valid = 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic write_reg(logic [pbpa_pkg::CSRI_W-1:0] idx, int unsigned value);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = pbpa_pkg::CSR_W'(value);
      @(negedge clock);
      csr_we    = 1'b0;
      case (idx)
         pbpa_pkg::REG_OBJECT_BYTES: pool_cfg[idx] = value & 'h1FFF;
         pbpa_pkg::REG_OBJS_PER_PG:  pool_cfg[idx] = value & 'h7F;
         pbpa_pkg::REG_HEADER_BYTES: pool_cfg[idx] = value & 'h3F;
         pbpa_pkg::REG_PAD_BYTES:    pool_cfg[idx] = value & 'h7F;
         pbpa_pkg::REG_MAX_PAGES:    pool_cfg[idx] = value & 'h1F;
         pbpa_pkg::REG_DEBUG_ON:     pool_cfg[idx] = value & 'h1;
         default: ;
      endcase
   endtask

   task automatic add_item(bit kind, int unsigned page, int unsigned offset,
                           bit typed, pbpa_pkg::rsp_type typed_rsp);
      row_type row;
      row = '{default: '0};
      row.item.kind        = kind;
      row.item.free_page   = pbpa_pkg::PAGE_W'(page);
      row.item.free_offset = pbpa_pkg::OFF_W'(offset);
      row.typed            = typed;
      row.typed_rsp        = typed_rsp;
      directed_rows.push_back(row);
   endtask

   task automatic add_csr(logic [pbpa_pkg::CSRI_W-1:0] idx, int unsigned value);
      row_type row;
      row = '{default: '0};
      row.is_csr    = 1'b1;
      row.reg_index = idx;
      row.reg_value = value;
      directed_rows.push_back(row);
   endtask

   // Builds a random request from the current model state. Most are legal
   // allocates and frees of live blocks; the rest are frees on a random page,
   // misaligned frees and raw noise.
   function automatic pbpa_pkg::req_type random_req();
      pbpa_pkg::req_type r;
      int unsigned       live_ids [$];
      int unsigned       pick;
      int unsigned       stride;
      int unsigned       roll;
      stride = stride_now();
      r      = '0;
      r.kind = pbpa_pkg::KIND_ALLOC;
      roll   = $urandom_range(99);
      for (int unsigned i = 0; i < page_count * pbpa_pkg::SLOTS_CAP; i++)
         if (id_live[i])
            live_ids.push_back(i);
      if (roll < 45 || (roll < 90 && live_ids.size() == 0)) begin
         r.free_page   = pbpa_pkg::PAGE_W'($urandom);
         r.free_offset = pbpa_pkg::OFF_W'($urandom);
      end else if (roll < 90) begin
         pick          = live_ids[$urandom_range(live_ids.size() - 1)];
         r.kind        = pbpa_pkg::KIND_FREE;
         r.free_page   = pbpa_pkg::PAGE_W'(pick / pbpa_pkg::SLOTS_CAP);
         r.free_offset = pbpa_pkg::OFF_W'(first_now()
                         + (pick % pbpa_pkg::SLOTS_CAP) * stride);
         if (roll >= 85 && stride > 1)
            r.free_offset += pbpa_pkg::OFF_W'($urandom_range(1, stride - 1));
         else if (roll >= 80)
            r.free_page = pbpa_pkg::PAGE_W'($urandom_range(page_count - 1));
      end else begin
         r.kind        = 1'($urandom);
         r.free_page   = pbpa_pkg::PAGE_W'($urandom);
         r.free_offset = pbpa_pkg::OFF_W'($urandom);
      end
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      pbpa_pkg::rsp_type zero_rsp;
      pbpa_pkg::rsp_type want;
      int unsigned       phase_items;

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      csr_we         = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      cur_typed      = 1'b0;
      cur_typed_rsp  = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_left      = 0;
      error_count    = 0;
      accepted_count = 0;
      checked_count  = 0;
      status_seen    = '{default: 0};
      pool_cfg       = '{8, 4, 0, 0, 16, 0};
      free_ids       = '{default: 0};
      id_live        = '{default: 1'b0};
      free_depth     = 0;
      page_count     = 0;
      alloc_total    = 0;
      live_total     = 0;
      zero_rsp       = '0;

      // Directed table. With the reset settings a slot is 8 bytes wide and
      // slot 0 starts right after the 8-byte link word.
      want = '0;
      want.status = pbpa_pkg::ST_BAD_BOUNDARY;
      add_item(pbpa_pkg::KIND_FREE, 0, 8, 1, want);   // free before any page
      want = '0;
      want.block_offset = 32; want.alloc_number = 1;
      want.free_count = 3;    want.in_use_count = 1;
      add_item(pbpa_pkg::KIND_ALLOC, 0, 0, 1, want);  // page added, slot 3 on top
      want.block_offset = 24; want.alloc_number = 2;
      want.free_count = 2;    want.in_use_count = 2;
      add_item(pbpa_pkg::KIND_ALLOC, 0, 0, 1, want);
      add_item(pbpa_pkg::KIND_FREE, 0, 32, 0, zero_rsp);       // legal free
      add_item(pbpa_pkg::KIND_FREE, 0, 32, 0, zero_rsp);       // repeated free is ignored
      add_item(pbpa_pkg::KIND_FREE, 0, 25, 0, zero_rsp);       // misaligned, truncated
      add_item(pbpa_pkg::KIND_FREE, 0, 0, 0, zero_rsp);        // before slot 0
      add_item(pbpa_pkg::KIND_FREE, 0, 40, 0, zero_rsp);       // past the last slot
      add_item(pbpa_pkg::KIND_FREE, 15, 'h7FFFF, 0, zero_rsp); // all ones, unknown page
      add_csr(pbpa_pkg::REG_DEBUG_ON, 1);
      add_item(pbpa_pkg::KIND_ALLOC, 0, 0, 0, zero_rsp);
      add_item(pbpa_pkg::KIND_FREE, 0, 8, 0, zero_rsp);        // free of an idle block
      add_item(pbpa_pkg::KIND_ALLOC, 0, 0, 0, zero_rsp);
      add_item(pbpa_pkg::KIND_FREE, 0, 9, 0, zero_rsp);        // misaligned in debug mode
      add_item(pbpa_pkg::KIND_FREE, 1, 8, 0, zero_rsp);        // unknown page in debug mode
      add_csr(pbpa_pkg::REG_MAX_PAGES, 1);
      repeat (5) add_item(pbpa_pkg::KIND_ALLOC, 0, 0, 0, zero_rsp); // runs out of pages

      repeat (10) @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_csr) begin
            drain();
            write_reg(directed_rows[i].reg_index, directed_rows[i].reg_value);
         end else begin
            send_req(directed_rows[i].item, directed_rows[i].typed,
                     directed_rows[i].typed_rsp);
         end
      end

      // Random phases. The first few pin register extremes, including values
      // above each register's range that the block must saturate; the rest
      // draw settings at random. Each phase runs its own idle pattern.
      for (int phase = 0; phase < 8; phase++) begin
         drain();
         case (phase)
            0: begin
               write_reg(pbpa_pkg::REG_OBJECT_BYTES, 8);
               write_reg(pbpa_pkg::REG_OBJS_PER_PG, 4);
               write_reg(pbpa_pkg::REG_HEADER_BYTES, 0);
               write_reg(pbpa_pkg::REG_PAD_BYTES, 0);
               write_reg(pbpa_pkg::REG_MAX_PAGES, 16);
               write_reg(pbpa_pkg::REG_DEBUG_ON, 0);
            end
            1: begin
               write_reg(pbpa_pkg::REG_OBJECT_BYTES, 4096);
               write_reg(pbpa_pkg::REG_OBJS_PER_PG, 64);
               write_reg(pbpa_pkg::REG_HEADER_BYTES, 32);
               write_reg(pbpa_pkg::REG_PAD_BYTES, 64);
               write_reg(pbpa_pkg::REG_MAX_PAGES, 16);
               write_reg(pbpa_pkg::REG_DEBUG_ON, 1);
            end
            2: begin
               write_reg(pbpa_pkg::REG_OBJECT_BYTES, 0);
               write_reg(pbpa_pkg::REG_OBJS_PER_PG, 0);
               write_reg(pbpa_pkg::REG_HEADER_BYTES, 63);
               write_reg(pbpa_pkg::REG_PAD_BYTES, 127);
               write_reg(pbpa_pkg::REG_MAX_PAGES, 31);
               write_reg(pbpa_pkg::REG_DEBUG_ON, 0);
            end
            3: begin
               write_reg(pbpa_pkg::REG_OBJECT_BYTES, 8191);
               write_reg(pbpa_pkg::REG_OBJS_PER_PG, 127);
               write_reg(pbpa_pkg::REG_HEADER_BYTES, 0);
               write_reg(pbpa_pkg::REG_PAD_BYTES, 0);
               write_reg(pbpa_pkg::REG_MAX_PAGES, 2);
               write_reg(pbpa_pkg::REG_DEBUG_ON, 1);
            end
            4: begin
               write_reg(pbpa_pkg::REG_OBJECT_BYTES, 1);
               write_reg(pbpa_pkg::REG_OBJS_PER_PG, 1);
               write_reg(pbpa_pkg::REG_MAX_PAGES, 0);
               write_reg(pbpa_pkg::REG_DEBUG_ON, 1);
            end
            default: begin
               write_reg(pbpa_pkg::REG_OBJECT_BYTES, $urandom_range(1, 300));
               write_reg(pbpa_pkg::REG_OBJS_PER_PG, $urandom_range(1, 20));
               write_reg(pbpa_pkg::REG_HEADER_BYTES, $urandom_range(0, 32));
               write_reg(pbpa_pkg::REG_PAD_BYTES, $urandom_range(0, 64));
               write_reg(pbpa_pkg::REG_MAX_PAGES, $urandom_range(0, 16));
               write_reg(pbpa_pkg::REG_DEBUG_ON, $urandom_range(0, 1));
            end
         endcase
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
            default: begin send_idle_pct = 31; recv_stall_pct = 31; end
         endcase
         // In the one-byte, zero-page phase hold the result side off for a long
         // stretch while the sender keeps offering, so the input backs up.
         if (phase == 4)
            hold_left = 400;
         phase_items = 0;
         while (phase_items < 92) begin
            send_req(random_req(), 1'b0, zero_rsp);
            phase_items++;
            // In phase 5 the sender pauses mid-phase until every result has come back.
            if (phase_items == 46 && phase == 5)
               drain();
         end
      end

      drain();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      while (pending_rsp.size() != 0) begin
         report_mismatch("missing result transaction", 0, 1);
         void'(pending_rsp.pop_front());
      end

      $display("Checked %0d result transactions over %0d pages and %0d allocations.",
               checked_count, page_count, alloc_total);
      $display("Status mix: ok %0d, out of pages %0d, multiple free %0d, bad boundary %0d.",
               status_seen[pbpa_pkg::ST_OK], status_seen[pbpa_pkg::ST_OUT_OF_PAGES],
               status_seen[pbpa_pkg::ST_MULTI_FREE], status_seen[pbpa_pkg::ST_BAD_BOUNDARY]);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
